// ===== sv/beop_pkg.sv =====
// Shared constants for the binomial European option pricer.
`default_nettype none
package beop_pkg;
    localparam int unsigned PriceW = 32;
    localparam int unsigned FactW  = 32;
    localparam int unsigned DivW   = 68;
    localparam int unsigned AccW   = 38;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [64:0] HALF_Q30 = 65'h0_2000_0000;
    localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SPOT = 2'd1;
    localparam logic [1:0] ST_ARB     = 2'd2;

    localparam logic [2:0] REG_STRIKE = 3'd0;
    localparam logic [2:0] REG_UP     = 3'd1;
    localparam logic [2:0] REG_DOWN   = 3'd2;
    localparam logic [2:0] REG_GROWTH = 3'd3;
    localparam logic [2:0] REG_STEPS  = 3'd4;
    localparam logic [2:0] REG_KIND   = 3'd5;

    localparam logic KIND_CALL = 1'b0;
    localparam logic KIND_PUT  = 1'b1;

    typedef logic [4:0] t_state;
endpackage
`default_nettype wire

// ===== sv/binomial_european_option_pricer.sv =====
// A zero spot or an arbitrage setup goes from the check state straight to the finishing state,
// which raises o_out_valid as soon as the output register is free.
// The pricer takes one beat at a time; a 32x32 multiplier and a restoring divider are shared.
// The divider serves the up probability, each binomial coefficient and each discount step.
// Reset (synchronous, active low) loads the default registers and empties both channels.
`default_nettype none
module binomial_european_option_pricer
    import beop_pkg::*;
#(
    parameter int MAX_STEPS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_spot_price,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_option_price,
    output logic [1:0]       o_status
);
    localparam int NW = $clog2(MAX_STEPS + 1);

    localparam t_state S_IDLE   = 5'd0;
    localparam t_state S_CHECK  = 5'd1;
    localparam t_state S_PDIV   = 5'd2;
    localparam t_state S_KSTART = 5'd3;
    localparam t_state S_PROB   = 5'd4;
    localparam t_state S_PROBW  = 5'd5;
    localparam t_state S_WMUL   = 5'd6;
    localparam t_state S_WMULW  = 5'd7;
    localparam t_state S_PRICE  = 5'd8;
    localparam t_state S_PRICEW = 5'd9;
    localparam t_state S_PAY    = 5'd10;
    localparam t_state S_PAYW   = 5'd11;
    localparam t_state S_BMUL   = 5'd12;
    localparam t_state S_BDIV   = 5'd13;
    localparam t_state S_BDIVW  = 5'd14;
    localparam t_state S_DISC   = 5'd15;
    localparam t_state S_DISCW  = 5'd16;
    localparam t_state S_FIN    = 5'd17;

    t_state r_state;

    logic [31:0] r_strike, r_up, r_down, r_growth;
    logic [3:0]  r_steps;
    logic        r_kind;

    logic [31:0]   r_s0, r_s, r_binom;
    logic [30:0]   r_p, r_q, r_prob, r_w;
    logic [NW-1:0] r_n, r_k, r_i;
    logic [AccW-1:0] r_acc;
    logic [63:0]   r_v;
    logic [31:0]   r_res_price;
    logic [1:0]    r_res_status;
    logic          r_out_valid;
    logic [31:0]   r_out_price;
    logic [1:0]    r_out_status;

    // Shared multiplier with a registered product.
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod;
    logic [64:0] rnd_sum;
    logic [34:0] rnd;

    // Shared restoring divider, one quotient bit per cycle.
    logic [DivW-1:0] r_dq;
    logic [32:0]     r_drem;
    logic [31:0]     r_dvs;
    logic [6:0]      r_dcnt;
    logic [32:0]     rem_sh, rem_nx;
    logic            div_ge;

    logic [NW-1:0] n_calc, nk;
    logic [31:0]   pay;
    logic          arb;
    logic [AccW-1:0] acc_sum;

    assign n_calc = (32'(r_steps) > 32'(MAX_STEPS)) ? NW'(MAX_STEPS) : NW'(r_steps);
    assign nk     = r_n - r_k;
    assign arb    = (r_down >= r_up) || (r_growth >= r_up) || (r_growth < r_down);

    always_comb begin
        if (r_kind == KIND_CALL) begin
            pay = (r_s > r_strike) ? r_s - r_strike : 32'd0;
        end else begin
            pay = (r_strike > r_s) ? r_strike - r_s : 32'd0;
        end
    end

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            S_PROB: begin
                mul_a = {1'b0, r_prob};
                mul_b = (r_i < r_k) ? {1'b0, r_p} : {1'b0, r_q};
            end
            S_WMUL: begin
                mul_a = r_binom;
                mul_b = {1'b0, r_prob};
            end
            S_PRICE: begin
                mul_a = r_s;
                mul_b = (r_i < nk) ? r_down : r_up;
            end
            S_PAY: begin
                mul_a = pay;
                mul_b = {1'b0, r_w};
            end
            S_BMUL: begin
                mul_a = r_binom;
                mul_b = 32'(nk);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign rnd_sum = {1'b0, r_prod} + HALF_Q30;
    assign rnd     = rnd_sum[64:30];
    assign acc_sum = r_acc + AccW'(rnd);

    assign rem_sh = {r_drem[31:0], r_dq[DivW-1]};
    assign div_ge = rem_sh >= {1'b0, r_dvs};
    assign rem_nx = div_ge ? rem_sh - {1'b0, r_dvs} : rem_sh;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dcnt      <= 7'd0;
            r_strike    <= 32'd6553600;
            r_up        <= 32'd1395864371;
            r_down      <= 32'd966367642;
            r_growth    <= 32'd1073741824;
            r_steps     <= 4'd3;
            r_kind      <= KIND_CALL;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_STRIKE: r_strike <= i_cfg_data;
                    REG_UP:     r_up     <= i_cfg_data;
                    REG_DOWN:   r_down   <= i_cfg_data;
                    REG_GROWTH: r_growth <= i_cfg_data;
                    REG_STEPS:  r_steps  <= i_cfg_data[3:0];
                    REG_KIND:   r_kind   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // The finishing state loads a new beat itself when the old one leaves.
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            if (r_dcnt != 7'd0) begin
                r_drem <= rem_nx;
                r_dq   <= {r_dq[DivW-2:0], div_ge};
                r_dcnt <= r_dcnt - 7'd1;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_s0    <= i_spot_price;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_n <= n_calc;
                    if (r_s0 == 32'd0) begin
                        r_res_price  <= 32'd0;
                        r_res_status <= ST_BAD_SPOT;
                        r_state      <= S_FIN;
                    end else if (arb) begin
                        r_res_price  <= 32'd0;
                        r_res_status <= ST_ARB;
                        r_state      <= S_FIN;
                    end else begin
                        r_dq    <= DivW'({r_growth - r_down, 30'd0});
                        r_dvs   <= r_up - r_down;
                        r_drem  <= 33'd0;
                        r_dcnt  <= 7'(DivW);
                        r_state <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (r_dcnt == 7'd0) begin
                        r_p     <= r_dq[30:0];
                        r_q     <= ONE_Q30 - r_dq[30:0];
                        r_k     <= '0;
                        r_binom <= 32'd1;
                        r_acc   <= '0;
                        r_state <= S_KSTART;
                    end
                end
                S_KSTART: begin
                    r_prob  <= ONE_Q30;
                    r_i     <= '0;
                    r_state <= S_PROB;
                end
                S_PROB: begin
                    r_state <= (r_i < r_n) ? S_PROBW : S_WMUL;
                end
                S_PROBW: begin
                    r_prob  <= rnd[30:0];
                    r_i     <= r_i + 1'b1;
                    r_state <= S_PROB;
                end
                S_WMUL: begin
                    r_state <= S_WMULW;
                end
                S_WMULW: begin
                    r_w     <= (r_prod > 64'(ONE_Q30)) ? ONE_Q30 : r_prod[30:0];
                    r_s     <= r_s0;
                    r_i     <= '0;
                    r_state <= S_PRICE;
                end
                S_PRICE: begin
                    r_state <= (r_i < r_n) ? S_PRICEW : S_PAY;
                end
                S_PRICEW: begin
                    // A terminal price that leaves 32 bits sticks at the maximum.
                    if (rnd > 35'(MAX32)) begin
                        r_s     <= MAX32;
                        r_state <= S_PAY;
                    end else begin
                        r_s     <= rnd[31:0];
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PRICE;
                    end
                end
                S_PAY: begin
                    r_state <= S_PAYW;
                end
                S_PAYW: begin
                    r_acc <= acc_sum;
                    if (r_k == r_n) begin
                        r_v     <= 64'(acc_sum);
                        r_i     <= '0;
                        r_state <= S_DISC;
                    end else begin
                        r_state <= S_BMUL;
                    end
                end
                S_BMUL: begin
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    r_dq    <= DivW'(r_prod);
                    r_dvs   <= 32'(r_k) + 32'd1;
                    r_drem  <= 33'd0;
                    r_dcnt  <= 7'(DivW);
                    r_state <= S_BDIVW;
                end
                S_BDIVW: begin
                    if (r_dcnt == 7'd0) begin
                        r_binom <= r_dq[31:0];
                        r_k     <= r_k + 1'b1;
                        r_state <= S_KSTART;
                    end
                end
                S_DISC: begin
                    r_res_status <= ST_OK;
                    if (r_i == r_n) begin
                        r_res_price <= (r_v > 64'(MAX32)) ? MAX32 : r_v[31:0];
                        r_state     <= S_FIN;
                    end else if (r_growth == 32'd0) begin
                        r_res_price <= (r_v != 64'd0) ? MAX32 : 32'd0;
                        r_state     <= S_FIN;
                    end else if ((r_growth < 32'(ONE_Q30)) && (r_v > 64'(MAX32))) begin
                        r_res_price <= MAX32;
                        r_state     <= S_FIN;
                    end else begin
                        // Rounded v * 2^30 / R in one division; v fits 38 bits here.
                        r_dq    <= {r_v[AccW-1:0], 30'd0} + DivW'(r_growth >> 1);
                        r_dvs   <= r_growth;
                        r_drem  <= 33'd0;
                        r_dcnt  <= 7'(DivW);
                        r_state <= S_DISCW;
                    end
                end
                S_DISCW: begin
                    if (r_dcnt == 7'd0) begin
                        r_v     <= r_dq[63:0];
                        r_i     <= r_i + 1'b1;
                        r_state <= S_DISC;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_price  <= r_res_price;
                        r_out_status <= r_res_status;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_option_price = r_out_price;
    assign o_status       = r_out_status;

`ifndef SYNTHESIS
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dcnt != 7'd0) |-> (r_state == S_PDIV || r_state == S_BDIVW || r_state == S_DISCW))
        else $error("divider busy outside a divide wait state");
    a_weight_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAY) |-> (r_w <= ONE_Q30))
        else $error("path weight above one");
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("accepted beat did not start a check");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_BAD_SPOT || o_status == ST_ARB))
        else $error("undefined status code");
`endif
endmodule
`default_nettype wire
